// ----- rtl/core/fbpa_pkg.sv -----
// Shared types and codes of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

  // Action codes of an input transaction
  localparam logic [2:0] ACT_INIT       = 3'd0;
  localparam logic [2:0] ACT_GET_WAIT   = 3'd1;
  localparam logic [2:0] ACT_GET_NOWAIT = 3'd2;
  localparam logic [2:0] ACT_FREE       = 3'd3;
  localparam logic [2:0] ACT_INFO       = 3'd4;
  localparam logic [2:0] ACT_DESTROY    = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNAVAILABLE = 3'd1;
  localparam logic [2:0] ST_QUEUED      = 3'd2;
  localparam logic [2:0] ST_DELETED     = 3'd3;
  localparam logic [2:0] ST_INIT_REJECT = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

  // Command kinds after classification by the front end
  localparam logic [2:0] KIND_INIT        = 3'd0;
  localparam logic [2:0] KIND_GET_WAIT    = 3'd1;
  localparam logic [2:0] KIND_GET_NOWAIT  = 3'd2;
  localparam logic [2:0] KIND_FREE        = 3'd3;
  localparam logic [2:0] KIND_INFO        = 3'd4;
  localparam logic [2:0] KIND_DESTROY     = 3'd5;
  localparam logic [2:0] KIND_INIT_REJECT = 3'd6;
  localparam logic [2:0] KIND_BAD         = 3'd7;

  // Depth of the command queue between front and back end
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] block_size;
    logic [6:0]  block_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  requester;
    logic [31:0] block_address;
  } cmd_t;

endpackage

// ----- rtl/core/fixed_block_pool_allocator_core.sv -----
// Top level of the fixed block pool allocator.
`timescale 1ns / 1ps

// Fixed block pool allocator. Start a transaction by raising start while busy is
// low; the front end classifies it into a two-entry command queue and the back
// end executes commands one at a time. Results appear at most one per cycle,
// each for a single cycle marked by done, and cannot be stalled; last flags the
// final result of a transaction. Info, queued or refused gets, frees into the
// free list and destroy with no waiters are finished in S_IDLE; a get that takes
// a block and a free handed to a waiter finish in S_GRANT or S_WAKE, after the
// registered read of the free list or waiter memory. Init writes min(block_count,
// POOL_DEPTH) free list entries in S_FILL, one per cycle; destroy with waiters
// reads one waiter per cycle in S_DRAIN and releases each one the cycle after it
// is read. Results are registered onto done in the cycle after the back end
// produces them. No clearing pass runs after reset.
// Configuration writes (cfg_valid, cfg_ready, always ready) are legal only
// while the block is idle.

module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int POOL_DEPTH      = 64,
  parameter int WAITER_DEPTH    = 16,
  parameter int MIN_BLOCK_BYTES = 8,
  localparam int FC = $clog2(POOL_DEPTH + 1),
  localparam int WC = $clog2(WAITER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    action,
  input  logic [7:0]    requester,
  input  logic [31:0]   block_address,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          done,
  output logic [2:0]    status,
  output logic [7:0]    target,
  output logic [31:0]   granted_address,
  output logic          woke_waiter,
  output logic [FC-1:0] free_count,
  output logic [WC-1:0] waiter_count,
  output logic          last
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_push;
  logic queue_full;
  logic head_valid;
  logic back_pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.block_size   <= 16'd8;
      cfg.block_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        REG_BLOCK_SIZE:   cfg.block_size   <= cfg_data[15:0];
        REG_BLOCK_COUNT:  cfg.block_count  <= cfg_data[6:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  fbpa_front #(
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .action        (action),
    .requester     (requester),
    .block_address (block_address),
    .block_size    (cfg.block_size),
    .queue_full    (queue_full),
    .push          (front_push),
    .cmd           (front_cmd)
  );

  fbpa_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_cmd   (front_cmd),
    .full       (queue_full),
    .pop        (back_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  fbpa_back #(
    .POOL_DEPTH   (POOL_DEPTH),
    .WAITER_DEPTH (WAITER_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd_valid       (head_valid),
    .cmd             (head_cmd),
    .pop             (back_pop),
    .done            (done),
    .status          (status),
    .target          (target),
    .granted_address (granted_address),
    .woke_waiter     (woke_waiter),
    .free_count      (free_count),
    .waiter_count    (waiter_count),
    .last            (last)
  );

endmodule

// ----- rtl/core/fbpa_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
`timescale 1ns / 1ps

module fbpa_front import fbpa_pkg::*; #(
  parameter int MIN_BLOCK_BYTES = 8
) (
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [7:0]  requester,
  input  logic [31:0] block_address,
  input  logic [15:0] block_size,
  input  logic        queue_full,
  output logic        push,
  output cmd_t        cmd
);

  logic size_ok;

  assign busy = queue_full;
  assign push = start && !queue_full;

  // Init is checked against the block size here; config must only change while idle, the block does not enforce it
  assign size_ok = (32'(block_size) >= 32'(MIN_BLOCK_BYTES));

  always_comb begin
    cmd.requester     = requester;
    cmd.block_address = block_address;
    case (action)
      ACT_INIT:       cmd.kind = size_ok ? KIND_INIT : KIND_INIT_REJECT;
      ACT_GET_WAIT:   cmd.kind = KIND_GET_WAIT;
      ACT_GET_NOWAIT: cmd.kind = KIND_GET_NOWAIT;
      ACT_FREE:       cmd.kind = KIND_FREE;
      ACT_INFO:       cmd.kind = KIND_INFO;
      ACT_DESTROY:    cmd.kind = KIND_DESTROY;
      default:        cmd.kind = KIND_BAD;
    endcase
  end

endmodule

// ----- rtl/core/fbpa_cmd_queue.sv -----
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module fbpa_cmd_queue import fbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entries [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/fbpa_back.sv -----
// Back end: free list and waiter FIFOs, command sequencer and result register.
`timescale 1ns / 1ps

module fbpa_back import fbpa_pkg::*; #(
  parameter int POOL_DEPTH   = 64,
  parameter int WAITER_DEPTH = 16,
  localparam int FC = $clog2(POOL_DEPTH + 1),
  localparam int WC = $clog2(WAITER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          pop,
  output logic          done,
  output logic [2:0]    status,
  output logic [7:0]    target,
  output logic [31:0]   granted_address,
  output logic          woke_waiter,
  output logic [FC-1:0] free_count,
  output logic [WC-1:0] waiter_count,
  output logic          last
);

  localparam int FI  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int WI  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int FSW = FC + 1;
  localparam int WSW = WC + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GRANT = 3'd1;
  localparam logic [2:0] S_WAKE  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  // Stores
  logic [31:0] fl_mem [POOL_DEPTH];
  logic [7:0]  wq_mem [WAITER_DEPTH];

  // Sequencer state
  logic [2:0]    state, state_next;
  logic [FI-1:0] free_head, free_head_next;
  logic [FC-1:0] free_fill, free_fill_next;
  logic [WI-1:0] waiter_head, waiter_head_next;
  logic [WC-1:0] waiter_fill, waiter_fill_next;
  logic [7:0]    req_hold, req_hold_next;
  logic [31:0]   addr_hold, addr_hold_next;
  logic [2:0]    init_status, init_status_next;
  logic [FI-1:0] fill_idx, fill_idx_next;
  logic [FC-1:0] fill_left, fill_left_next;
  logic [FC-1:0] fill_total, fill_total_next;
  logic [WI-1:0] drain_ptr, drain_ptr_next;
  logic [WC-1:0] issue_left, issue_left_next;
  logic          pend, pend_next;

  // Memory ports
  logic          fl_we, fl_re;
  logic [FI-1:0] fl_waddr;
  logic [31:0]   fl_wdata, fl_rdata;
  logic          wq_we, wq_re;
  logic [WI-1:0] wq_waddr, wq_raddr;
  logic [7:0]    wq_rdata;

  // Result being produced this cycle
  logic        emit;
  logic [2:0]  emit_status;
  logic [7:0]  emit_target;
  logic [31:0] emit_addr;
  logic        emit_woke;
  logic        emit_last;

  // Derived values
  logic [FSW-1:0] free_tail_sum;
  logic [FI-1:0]  free_tail;
  logic [WSW-1:0] waiter_tail_sum;
  logic [WI-1:0]  waiter_tail;
  logic [FI-1:0]  free_head_inc;
  logic [WI-1:0]  waiter_head_inc;
  logic [WI-1:0]  drain_ptr_inc;
  logic           count_over;
  logic [FC-1:0]  init_n;

  assign free_tail_sum = FSW'(free_head) + FSW'(free_fill);
  assign free_tail = (free_tail_sum >= FSW'(POOL_DEPTH)) ?
                     FI'(free_tail_sum - FSW'(POOL_DEPTH)) : FI'(free_tail_sum);
  assign waiter_tail_sum = WSW'(waiter_head) + WSW'(waiter_fill);
  assign waiter_tail = (waiter_tail_sum >= WSW'(WAITER_DEPTH)) ?
                       WI'(waiter_tail_sum - WSW'(WAITER_DEPTH)) : WI'(waiter_tail_sum);
  assign free_head_inc = (free_head == FI'(POOL_DEPTH - 1)) ? '0 : free_head + FI'(1);
  assign waiter_head_inc = (waiter_head == WI'(WAITER_DEPTH - 1)) ?
                           '0 : waiter_head + WI'(1);
  assign drain_ptr_inc = (drain_ptr == WI'(WAITER_DEPTH - 1)) ? '0 : drain_ptr + WI'(1);
  assign count_over = (32'(cfg.block_count) > 32'(POOL_DEPTH));
  assign init_n = count_over ? FC'(POOL_DEPTH) : FC'(cfg.block_count);

  // Command sequencer
  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    free_fill_next   = free_fill;
    waiter_head_next = waiter_head;
    waiter_fill_next = waiter_fill;
    req_hold_next    = req_hold;
    addr_hold_next   = addr_hold;
    init_status_next = init_status;
    fill_idx_next    = fill_idx;
    fill_left_next   = fill_left;
    fill_total_next  = fill_total;
    drain_ptr_next   = drain_ptr;
    issue_left_next  = issue_left;
    pend_next        = pend;
    pop         = 1'b0;
    fl_we       = 1'b0;
    fl_re       = 1'b0;
    fl_waddr    = free_tail;
    fl_wdata    = cmd.block_address;
    wq_we       = 1'b0;
    wq_re       = 1'b0;
    wq_waddr    = waiter_tail;
    wq_raddr    = waiter_head;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_target = cmd.requester;
    emit_addr   = '0;
    emit_woke   = 1'b0;
    emit_last   = 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.kind)
            KIND_INIT: begin
              waiter_head_next = '0;
              waiter_fill_next = '0;
              free_head_next   = '0;
              free_fill_next   = '0;
              init_status_next = count_over ? ST_OVERFLOW : ST_OK;
              addr_hold_next   = cfg.base_address;
              fill_idx_next    = '0;
              fill_left_next   = init_n;
              fill_total_next  = init_n;
              req_hold_next    = cmd.requester;
              if (init_n == '0) begin
                emit        = 1'b1;
                emit_status = count_over ? ST_OVERFLOW : ST_OK;
              end else begin
                state_next = S_FILL;
              end
            end
            KIND_GET_WAIT, KIND_GET_NOWAIT: begin
              if (free_fill != '0) begin
                fl_re          = 1'b1;
                free_head_next = free_head_inc;
                free_fill_next = free_fill - FC'(1);
                req_hold_next  = cmd.requester;
                state_next     = S_GRANT;
              end else if (cmd.kind == KIND_GET_WAIT &&
                           waiter_fill < WC'(WAITER_DEPTH)) begin
                wq_we            = 1'b1;
                waiter_fill_next = waiter_fill + WC'(1);
                emit             = 1'b1;
                emit_status      = ST_QUEUED;
              end else begin
                emit        = 1'b1;
                emit_status = (cmd.kind == KIND_GET_WAIT) ? ST_OVERFLOW : ST_UNAVAILABLE;
              end
            end
            KIND_FREE: begin
              if (waiter_fill != '0) begin
                // hand the block straight to the oldest waiter
                wq_re            = 1'b1;
                waiter_head_next = waiter_head_inc;
                waiter_fill_next = waiter_fill - WC'(1);
                addr_hold_next   = cmd.block_address;
                state_next       = S_WAKE;
              end else if (free_fill != FC'(POOL_DEPTH)) begin
                fl_we          = 1'b1;
                free_fill_next = free_fill + FC'(1);
                emit           = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_status = ST_OVERFLOW;
              end
            end
            KIND_INFO: begin
              emit = 1'b1;
            end
            KIND_DESTROY: begin
              if (waiter_fill == '0) begin
                emit = 1'b1;
              end else begin
                drain_ptr_next   = waiter_head;
                issue_left_next  = waiter_fill;
                pend_next        = 1'b0;
                waiter_head_next = '0;
                waiter_fill_next = '0;
                state_next       = S_DRAIN;
              end
            end
            KIND_INIT_REJECT: begin
              emit        = 1'b1;
              emit_status = ST_INIT_REJECT;
            end
            default: begin
              emit        = 1'b1;
              emit_status = ST_UNAVAILABLE;
            end
          endcase
        end
      end

      S_GRANT: begin
        emit        = 1'b1;
        emit_target = req_hold;
        emit_addr   = fl_rdata;
        state_next  = S_IDLE;
      end

      S_WAKE: begin
        emit        = 1'b1;
        emit_target = wq_rdata;
        emit_addr   = addr_hold;
        emit_woke   = 1'b1;
        state_next  = S_IDLE;
      end

      // One free list entry per cycle: base + i * block_size
      S_FILL: begin
        fl_we          = 1'b1;
        fl_waddr       = fill_idx;
        fl_wdata       = addr_hold;
        addr_hold_next = addr_hold + 32'(cfg.block_size);
        fill_idx_next  = fill_idx + FI'(1);
        fill_left_next = fill_left - FC'(1);
        if (fill_left == FC'(1)) begin
          free_fill_next = fill_total;
          emit           = 1'b1;
          emit_status    = init_status;
          emit_target    = req_hold;
          state_next     = S_IDLE;
        end
      end

      // Read one waiter per cycle, release the one read the cycle before
      S_DRAIN: begin
        wq_raddr = drain_ptr;
        if (issue_left != '0) begin
          wq_re           = 1'b1;
          drain_ptr_next  = drain_ptr_inc;
          issue_left_next = issue_left - WC'(1);
        end
        pend_next = (issue_left != '0);
        if (pend) begin
          emit        = 1'b1;
          emit_status = ST_DELETED;
          emit_target = wq_rdata;
          emit_woke   = 1'b1;
          emit_last   = (issue_left == '0);
          if (issue_left == '0) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Free list memory
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= fl_wdata;
    end
    if (fl_re) begin
      fl_rdata <= fl_mem[free_head];
    end
  end

  // Waiter queue memory
  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq_mem[wq_waddr] <= cmd.requester;
    end
    if (wq_re) begin
      wq_rdata <= wq_mem[wq_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      free_fill   <= '0;
      waiter_head <= '0;
      waiter_fill <= '0;
      pend        <= 1'b0;
      issue_left  <= '0;
      fill_left   <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      free_fill   <= free_fill_next;
      waiter_head <= waiter_head_next;
      waiter_fill <= waiter_fill_next;
      pend        <= pend_next;
      issue_left  <= issue_left_next;
      fill_left   <= fill_left_next;
      done        <= emit;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    req_hold    <= req_hold_next;
    addr_hold   <= addr_hold_next;
    init_status <= init_status_next;
    fill_idx    <= fill_idx_next;
    fill_total  <= fill_total_next;
    drain_ptr   <= drain_ptr_next;
    if (emit) begin
      status          <= emit_status;
      target          <= emit_target;
      granted_address <= emit_addr;
      woke_waiter     <= emit_woke;
      free_count      <= free_fill_next;
      waiter_count    <= waiter_fill_next;
      last            <= emit_last;
    end
  end

endmodule

// ----- rtl/core/fbpa_checker.sv -----
// Port-level checker of the allocator and its bind to the top level.
`timescale 1ns / 1ps

module fbpa_checker import fbpa_pkg::*; #(
  parameter int POOL_DEPTH   = 64,
  parameter int WAITER_DEPTH = 16,
  localparam int FC = $clog2(POOL_DEPTH + 1),
  localparam int WC = $clog2(WAITER_DEPTH + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          done,
  input logic [2:0]    status,
  input logic [31:0]   granted_address,
  input logic          woke_waiter,
  input logic [FC-1:0] free_count,
  input logic [WC-1:0] waiter_count,
  input logic          last
);

  // No result in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe right after reset");

  // Only destroy spreads over several results
  a_multi_only_destroy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> status == ST_DELETED)
    else $error("non-final result outside destroy");

  // A released waiter got either a block or a deletion
  a_woke_status: assert property (@(posedge clk) disable iff (rst)
    done && woke_waiter |-> status == ST_OK || status == ST_DELETED)
    else $error("woken waiter with wrong status");

  // Destroy empties the waiter queue and grants nothing
  a_deleted_empty: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DELETED |-> waiter_count == '0 && granted_address == '0)
    else $error("deleted result with waiters left or an address");

  // Counts never exceed the store depths
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(free_count) <= 32'(POOL_DEPTH) && 32'(waiter_count) <= 32'(WAITER_DEPTH))
    else $error("count beyond store depth");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker #(
  .POOL_DEPTH   (POOL_DEPTH),
  .WAITER_DEPTH (WAITER_DEPTH)
) u_fbpa_checker (
  .clk             (clk),
  .rst             (rst),
  .done            (done),
  .status          (status),
  .granted_address (granted_address),
  .woke_waiter     (woke_waiter),
  .free_count      (free_count),
  .waiter_count    (waiter_count),
  .last            (last)
);
